// ----- rtl/ptt_pkg.sv -----
// Shared types and codes for the periodic task timer table.
package ptt_pkg;

  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_REG    = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_SET    = 3'd3;
  localparam logic [2:0] ACT_UPDATE = 3'd4;

  localparam logic [1:0] KIND_FIRE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] interval;
    logic [15:0] repeat_lim;
    logic [31:0] tick;
    logic [15:0] fire_count;
    logic        queued;
    logic        pend;
  } slot_t;

  typedef struct packed {
    logic cap;
    logic rd_idx;
    logic rd_prev;
    logic rd_last;
    logic tick_upd;
    logic dec_active;
    logic mv_wr;
    logic reg_try;
    logic idx_inc;
    logic idx_dec;
    logic idx_to_active;
    logic mark_wr;
    logic upd_wr;
    logic zero_wr;
    logic div_start;
    logic div_wr;
    logic fb_rd;
    logic fire_out;
    logic fin_out;
    logic ack_out;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       idx_lt_active;
    logic       idx_zero;
    logic       idx_is_last;
    logic       match;
    logic       rm;
    logic       ival_zero;
    logic       div_done;
    logic       fb_done;
    logic       out_free;
  } sts_t;

endpackage

// ----- rtl/periodic_task_timer_table_core.sv -----
// Top level of the periodic task timer table.
// Remove, set and update walk the slots; set tick runs the remainder unit for each matching
// slot with a nonzero interval. A tick walks every active slot, then a removal scan, then
// emits one result per fire.
// One request at a time; the slot memory port and the bit-serial remainder set the rate.
// Synchronous active-low reset empties the table; slot contents stay undefined until written.
module periodic_task_timer_table_core #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // function_id, interval, repeat_limit, use_queue, tic_value
  input  logic [2:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // fired_id, fired_queued, status, active_count
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast
);
  import ptt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ptt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptt_dp #(.SLOTS(SLOTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_action (in_tuser),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );
endmodule

// ----- rtl/ptt_div.sv -----
// Restoring remainder unit, one quotient bit per cycle.
module ptt_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] rem
);
  logic [31:0] n_r, n_nxt, r_r, r_nxt, d_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] rs;

  always_comb begin
    rs    = {r_r, n_r[31]};
    n_nxt = {n_r[30:0], 1'b0};
    if (rs >= {1'b0, d_r}) begin
      r_nxt = 32'(rs - {1'b0, d_r});
    end else begin
      r_nxt = rs[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r <= num;
      d_r <= den;
      r_r <= '0;
    end else if (busy_r) begin
      n_r <= n_nxt;
      r_r <= r_nxt;
    end
  end

  assign done = done_r;
  assign rem  = r_r;
endmodule

// ----- rtl/ptt_ctrl.sv -----
// Sequencer for the timer table: walks slots, removal scan and result emission.
module ptt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  ptt_pkg::sts_t sts,
  output ptt_pkg::cmd_t cmd
);
  import ptt_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_DISP  = 15'b000000000000010,
    S_REG   = 15'b000000000000100,
    S_T_RD  = 15'b000000000001000,
    S_T_EV  = 15'b000000000010000,
    S_R_CHK = 15'b000000000100000,
    S_R_EV  = 15'b000000001000000,
    S_R_MV  = 15'b000000010000000,
    S_S_RD  = 15'b000000100000000,
    S_S_EV  = 15'b000001000000000,
    S_S_DIV = 15'b000010000000000,
    S_F_CHK = 15'b000100000000000,
    S_F_OUT = 15'b001000000000000,
    S_F_FIN = 15'b010000000000000,
    S_ACK   = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.action)
          ACT_TICK:                       state_nxt = S_T_RD;
          ACT_REG:                        state_nxt = S_REG;
          ACT_REMOVE, ACT_SET, ACT_UPDATE: state_nxt = S_S_RD;
          default:                        state_nxt = S_ACK;
        endcase
      end
      S_REG: begin
        cmd.reg_try = 1'b1;
        state_nxt   = S_ACK;
      end
      S_T_RD: begin
        if (sts.idx_lt_active) begin
          cmd.rd_idx = 1'b1;
          state_nxt  = S_T_EV;
        end else begin
          cmd.idx_to_active = 1'b1;
          state_nxt         = S_R_CHK;
        end
      end
      S_T_EV: begin
        cmd.tick_upd = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = S_T_RD;
      end
      S_R_CHK: begin
        if (sts.idx_zero) begin
          state_nxt = S_F_CHK;
        end else begin
          cmd.rd_prev = 1'b1;
          cmd.idx_dec = 1'b1;
          state_nxt   = S_R_EV;
        end
      end
      S_R_EV: begin
        state_nxt = S_R_CHK;
        if (sts.rm) begin
          cmd.dec_active = 1'b1;
          if (!sts.idx_is_last) begin
            cmd.rd_last = 1'b1;
            state_nxt   = S_R_MV;
          end
        end
      end
      S_R_MV: begin
        cmd.mv_wr = 1'b1;
        state_nxt = S_R_CHK;
      end
      S_S_RD: begin
        if (sts.idx_lt_active) begin
          cmd.rd_idx = 1'b1;
          state_nxt  = S_S_EV;
        end else begin
          state_nxt = S_ACK;
        end
      end
      S_S_EV: begin
        cmd.idx_inc = 1'b1;
        state_nxt   = S_S_RD;
        if (sts.match) begin
          case (sts.action)
            ACT_REMOVE: cmd.mark_wr = 1'b1;
            ACT_UPDATE: begin
              cmd.upd_wr  = 1'b1;
              cmd.idx_inc = 1'b0;
              state_nxt   = S_ACK;
            end
            default: begin
              if (sts.ival_zero) begin
                cmd.zero_wr = 1'b1;
              end else begin
                cmd.div_start = 1'b1;
                cmd.idx_inc   = 1'b0;
                state_nxt     = S_S_DIV;
              end
            end
          endcase
        end
      end
      S_S_DIV: begin
        if (sts.div_done) begin
          cmd.div_wr  = 1'b1;
          cmd.idx_inc = 1'b1;
          state_nxt   = S_S_RD;
        end
      end
      S_F_CHK: begin
        if (sts.fb_done) begin
          state_nxt = S_F_FIN;
        end else begin
          cmd.fb_rd = 1'b1;
          state_nxt = S_F_OUT;
        end
      end
      S_F_OUT: begin
        if (sts.out_free) begin
          cmd.fire_out = 1'b1;
          state_nxt    = S_F_CHK;
        end
      end
      S_F_FIN: begin
        if (sts.out_free) begin
          cmd.fin_out = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_ACK: begin
        if (sts.out_free) begin
          cmd.ack_out = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// ----- rtl/ptt_dp.sv -----
// Datapath for the timer table: slot memory, fire buffer, counters and output register.
module ptt_dp #(
  parameter int SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [2:0]    in_action,
  input  logic [95:0]   in_data,
  input  ptt_pkg::cmd_t cmd,
  output ptt_pkg::sts_t sts,
  input  logic          out_tready,
  output logic          out_tvalid,
  output logic [15:0]   out_tdata,
  output logic [1:0]    out_tuser,
  output logic          out_tlast
);
  import ptt_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] FULLC = CW'(SLOTS);
  localparam logic [CW-1:0] ONE   = CW'(1);

  slot_t       mem [SLOTS];
  logic [8:0]  fbuf [SLOTS];
  slot_t       rdata_r, wr_data, rec;
  logic [8:0]  fq_r;
  logic [CW-1:0] idx_r, active_r, fcnt_r, frd_r, act_m1, idx_m1;
  logic [2:0]  act_r;
  logic [7:0]  id_r;
  logic [31:0] ival_r, tic_r;
  logic [15:0] rep_r;
  logic        q_r, found_r, fail_r;
  logic        rd_en, wr_en, fire;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [31:0] tick_inc, div_rem;
  logic        div_done;
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic [1:0]  out_user_r, ack_st;
  logic        out_last_r, full;
  logic [3:0]  active4;

  ptt_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num  (tic_r),
    .den  (rdata_r.interval),
    .done (div_done),
    .rem  (div_rem)
  );

  assign act_m1   = active_r - ONE;
  assign idx_m1   = idx_r - ONE;
  assign full     = (active_r == FULLC);
  assign tick_inc = rdata_r.tick + 32'd1;
  assign fire     = (tick_inc >= rdata_r.interval);
  assign active4  = 4'(active_r);

  always_comb begin
    rd_en   = cmd.rd_idx | cmd.rd_prev | cmd.rd_last;
    rd_addr = idx_r[IW-1:0];
    if (cmd.rd_prev) rd_addr = idx_m1[IW-1:0];
    if (cmd.rd_last) rd_addr = act_m1[IW-1:0];

    rec     = rdata_r;
    wr_en   = 1'b1;
    wr_addr = idx_r[IW-1:0];
    if (cmd.tick_upd) begin
      rec.tick       = fire ? 32'd0 : tick_inc;
      rec.fire_count = fire ? 16'(rdata_r.fire_count + 16'd1) : rdata_r.fire_count;
    end else if (cmd.reg_try && !full) begin
      wr_addr         = active_r[IW-1:0];
      rec.id          = id_r;
      rec.interval    = ival_r;
      rec.repeat_lim  = rep_r;
      rec.tick        = '0;
      rec.fire_count  = '0;
      rec.queued      = q_r;
      rec.pend        = 1'b0;
    end else if (cmd.mark_wr) begin
      rec.pend = 1'b1;
    end else if (cmd.upd_wr) begin
      rec.interval = ival_r;
      rec.tick     = '0;
    end else if (cmd.zero_wr) begin
      rec.tick = '0;
    end else if (cmd.div_wr) begin
      rec.tick = div_rem;
    end else if (!cmd.mv_wr) begin
      wr_en = 1'b0;
    end
    wr_data = rec;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
    if (cmd.tick_upd && fire) fbuf[fcnt_r[IW-1:0]] <= {rdata_r.queued, rdata_r.id};
    if (cmd.fb_rd) fq_r <= fbuf[frd_r[IW-1:0]];
    if (cmd.cap) begin
      act_r  <= in_action;
      id_r   <= in_data[7:0];
      ival_r <= in_data[39:8];
      rep_r  <= in_data[55:40];
      q_r    <= in_data[56];
      tic_r  <= in_data[88:57];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      idx_r    <= '0;
      fcnt_r   <= '0;
      frd_r    <= '0;
      found_r  <= 1'b0;
      fail_r   <= 1'b0;
    end else begin
      if (cmd.cap) begin
        idx_r   <= '0;
        fcnt_r  <= '0;
        frd_r   <= '0;
        found_r <= 1'b0;
        fail_r  <= 1'b0;
      end
      if (cmd.idx_inc) idx_r <= idx_r + ONE;
      if (cmd.idx_dec) idx_r <= idx_m1;
      if (cmd.idx_to_active) idx_r <= active_r;
      if (cmd.dec_active) active_r <= act_m1;
      if (cmd.reg_try) begin
        if (full) fail_r <= 1'b1;
        else active_r <= active_r + ONE;
      end
      if (cmd.tick_upd && fire) fcnt_r <= fcnt_r + ONE;
      if (cmd.fire_out) frd_r <= frd_r + ONE;
      if (cmd.mark_wr || cmd.upd_wr || cmd.zero_wr || cmd.div_wr) found_r <= 1'b1;
    end
  end

  always_comb begin
    case (act_r)
      ACT_REG:                        ack_st = fail_r ? ST_FULL : ST_OK;
      ACT_REMOVE, ACT_SET, ACT_UPDATE: ack_st = found_r ? ST_OK : ST_NOTFOUND;
      default:                        ack_st = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fire_out || cmd.fin_out || cmd.ack_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire_out) begin
      out_user_r <= KIND_FIRE;
      out_data_r <= {1'b0, active4, ST_OK, fq_r[8], fq_r[7:0]};
      out_last_r <= 1'b0;
    end else if (cmd.fin_out) begin
      out_user_r <= KIND_DONE;
      out_data_r <= {1'b0, active4, ST_OK, 1'b0, 8'd0};
      out_last_r <= 1'b1;
    end else if (cmd.ack_out) begin
      out_user_r <= KIND_ACK;
      out_data_r <= {1'b0, active4, ack_st, 1'b0, id_r};
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    sts               = '0;
    sts.action        = act_r;
    sts.idx_lt_active = (idx_r < active_r);
    sts.idx_zero      = (idx_r == '0);
    sts.idx_is_last   = (idx_r == act_m1);
    sts.match         = (rdata_r.id == id_r);
    sts.rm            = rdata_r.pend ||
                        (!rdata_r.repeat_lim[15] && rdata_r.fire_count == rdata_r.repeat_lim);
    sts.ival_zero     = (rdata_r.interval == '0);
    sts.div_done      = div_done;
    sts.fb_done       = (frd_r == fcnt_r);
    sts.out_free      = !out_valid_r || out_tready;
  end

  a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r <= FULLC) else $error("active count beyond table size");
  a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= active_r || fcnt_r <= FULLC) else $error("fire buffer overrun");
  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.fire_out, cmd.fin_out, cmd.ack_out})) else $error("double output load");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fire_out || cmd.fin_out || cmd.ack_out) |-> (!out_valid_r || out_tready))
    else $error("output overwritten while held");
endmodule

// ----- tb/ptt_checker.sv -----
// Checker for the periodic task timer table: predicts results from requests and compares.
module ptt_checker #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_count,
  output int          fire_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import ptt_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] id;
    logic       queued;
    logic [1:0] status;
    logic [3:0] active;
    logic       last;
  } result_t;

  logic [7:0]  tbl_id       [SLOTS];
  logic [31:0] tbl_interval [SLOTS];
  logic [15:0] tbl_repeat   [SLOTS];
  logic [31:0] tbl_tick     [SLOTS];
  logic [15:0] tbl_fires    [SLOTS];
  logic        tbl_queued   [SLOTS];
  logic        tbl_marked   [SLOTS];
  int          n_active;
  result_t     expected_q[$];

  assign pending_count = expected_q.size();

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic bit limit_hit(input int i);
    return !tbl_repeat[i][15] && tbl_fires[i] == tbl_repeat[i];
  endfunction

  task automatic predict(input logic [2:0] act, input logic [95:0] d);
    logic [7:0]  id;
    logic [31:0] ival;
    logic [15:0] rep;
    logic        q;
    logic [31:0] tic;
    logic [1:0]  st;
    bit          found;
    result_t     fires[$];
    result_t     r;
    id = d[7:0]; ival = d[39:8]; rep = d[55:40]; q = d[56]; tic = d[88:57];
    st = ST_OK;
    found = 0;
    case (act)
      ACT_TICK: begin
        for (int i = 0; i < n_active; i++) begin
          tbl_tick[i]++;
          if (tbl_tick[i] >= tbl_interval[i]) begin
            r = '0;
            r.kind = KIND_FIRE; r.id = tbl_id[i]; r.queued = tbl_queued[i];
            fires.push_back(r);
            tbl_tick[i] = 0;
            tbl_fires[i]++;
          end
        end
        for (int i = n_active - 1; i >= 0; i--) begin
          if (limit_hit(i) || tbl_marked[i]) begin
            n_active--;
            if (i != n_active) begin
              tbl_id[i] = tbl_id[n_active]; tbl_interval[i] = tbl_interval[n_active];
              tbl_repeat[i] = tbl_repeat[n_active]; tbl_tick[i] = tbl_tick[n_active];
              tbl_fires[i] = tbl_fires[n_active]; tbl_queued[i] = tbl_queued[n_active];
              tbl_marked[i] = tbl_marked[n_active];
            end
            tbl_marked[n_active] = 0;
          end
        end
        foreach (fires[k]) begin
          fires[k].active = n_active[3:0];
          expected_q.push_back(fires[k]);
        end
        r = '0;
        r.kind = KIND_DONE; r.active = n_active[3:0]; r.last = 1;
        expected_q.push_back(r);
        return;
      end
      ACT_REG: begin
        if (n_active >= SLOTS) st = ST_FULL;
        else begin
          tbl_id[n_active] = id; tbl_interval[n_active] = ival; tbl_repeat[n_active] = rep;
          tbl_tick[n_active] = 0; tbl_fires[n_active] = 0; tbl_queued[n_active] = q;
          tbl_marked[n_active] = 0;
          n_active++;
        end
      end
      ACT_REMOVE: begin
        for (int i = 0; i < n_active; i++)
          if (tbl_id[i] == id) begin tbl_marked[i] = 1; found = 1; end
        st = found ? ST_OK : ST_NOTFOUND;
      end
      ACT_SET: begin
        for (int i = 0; i < n_active; i++)
          if (tbl_id[i] == id) begin
            tbl_tick[i] = tbl_interval[i] != 0 ? tic % tbl_interval[i] : 32'd0;
            found = 1;
          end
        st = found ? ST_OK : ST_NOTFOUND;
      end
      ACT_UPDATE: begin
        for (int i = 0; i < n_active; i++)
          if (tbl_id[i] == id) begin
            tbl_interval[i] = ival; tbl_tick[i] = 0; found = 1;
            break;
          end
        st = found ? ST_OK : ST_NOTFOUND;
      end
      default: ;
    endcase
    r = '0;
    r.kind = KIND_ACK; r.id = id; r.status = st; r.active = n_active[3:0]; r.last = 1;
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      n_active = 0;
      fail_count = 0;
      fire_seen = 0;
      expected_q.delete();
      for (int i = 0; i < SLOTS; i++) tbl_marked[i] = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) report("unexpected result", out_tdata, 16'h0);
        else begin
          want = expected_q.pop_front();
          if (out_tuser == KIND_FIRE) fire_seen++;
          if (out_tuser !== want.kind) report("kind", 16'(out_tuser), 16'(want.kind));
          if (out_tdata[7:0] !== want.id)
            report("fired_id", 16'(out_tdata[7:0]), 16'(want.id));
          if (out_tdata[8] !== want.queued)
            report("fired_queued", 16'(out_tdata[8]), 16'(want.queued));
          if (out_tdata[10:9] !== want.status)
            report("status", 16'(out_tdata[10:9]), 16'(want.status));
          if (out_tdata[14:11] !== want.active)
            report("active_count", 16'(out_tdata[14:11]), 16'(want.active));
          if (out_tlast !== want.last) report("last", 16'(out_tlast), 16'(want.last));
        end
      end
      if (in_tvalid && in_tready) predict(in_tuser, in_tdata);
    end
  end
endmodule

// ----- tb/testbench.sv -----
// Top of the timer table testbench: stimulus, handshake pacing and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ptt_pkg::*;

  localparam int SLOTS = 8;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending_count;
  int          fire_seen;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          n_requests;
  logic [7:0]  id_pool[4] = '{8'h00, 8'hFF, 8'h5A, 8'h21};

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  periodic_task_timer_table_core #(.SLOTS(SLOTS)) DUT (.*);

  ptt_checker #(.SLOTS(SLOTS)) checker_i (.*);

  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic send(input logic [2:0] act, input logic [7:0] id, input logic [31:0] ival,
                      input logic [15:0] rep, input logic q, input logic [31:0] tic);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      in_tdata <= {$urandom, $urandom, $urandom};
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= act;
    in_tdata <= {7'd0, tic, q, rep, ival, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    n_requests++;
  endtask

  task automatic send_random();
    int pick;
    logic [7:0]  id;
    logic [31:0] ival;
    logic [15:0] rep;
    pick = $urandom_range(99);
    id = $urandom_range(3) == 0 ? 8'($urandom) : id_pool[$urandom_range(3)];
    ival = $urandom_range(9) == 0 ? $urandom : 32'($urandom_range(6));
    rep = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4) - 1);
    if (pick < 45)
      send(ACT_TICK, 8'($urandom), $urandom, 16'($urandom), 1'($urandom), $urandom);
    else if (pick < 65) send(ACT_REG, id, ival, rep, 1'($urandom), $urandom);
    else if (pick < 75)
      send(ACT_REMOVE, id, $urandom, 16'($urandom), 1'($urandom), $urandom);
    else if (pick < 85) send(ACT_SET, id, $urandom, 16'($urandom), 1'($urandom), $urandom);
    else if (pick < 95) send(ACT_UPDATE, id, ival, 16'($urandom), 1'($urandom), $urandom);
    else send(3'($urandom_range(7, 5)), id, $urandom, 16'($urandom), 1'($urandom), $urandom);
  endtask

  initial begin
    n_requests = 0;
    send_idle_pct = 9;
    recv_idle_pct = 88;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    send(ACT_TICK, 8'h00, 32'h0, 16'h0, 1'b0, 32'h0);
    send(ACT_REMOVE, 8'h11, 32'h0, 16'h0, 1'b0, 32'h0);
    send(ACT_SET, 8'h11, 32'h0, 16'h0, 1'b0, 32'h5);
    send(ACT_UPDATE, 8'h11, 32'h3, 16'h0, 1'b0, 32'h0);
    send(ACT_REG, 8'hFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 32'hFFFFFFFF);
    send(ACT_REG, 8'h00, 32'h0, 16'h0, 1'b0, 32'h0);
    send(ACT_REG, 8'h5A, 32'h0, 16'h7FFF, 1'b1, 32'h0);
    send(ACT_REG, 8'h21, 32'h2, 16'h2, 1'b0, 32'h0);
    send(ACT_REG, 8'h21, 32'h1, 16'h8000, 1'b1, 32'h0);
    send(ACT_REG, 8'h33, 32'h3, 16'hFFFF, 1'b0, 32'h0);
    send(ACT_REG, 8'h44, 32'h4, 16'h1, 1'b1, 32'h0);
    send(ACT_REG, 8'h55, 32'h1, 16'h3, 1'b0, 32'h0);
    send(ACT_REG, 8'h66, 32'h1, 16'h1, 1'b0, 32'h0);
    send(ACT_SET, 8'hFF, 32'h0, 16'h0, 1'b0, 32'hFFFFFFFF);
    send(ACT_SET, 8'h5A, 32'h0, 16'h0, 1'b0, 32'h12345678);
    send(ACT_SET, 8'h21, 32'h0, 16'h0, 1'b0, 32'h7);
    send(ACT_TICK, 8'h00, 32'h0, 16'h0, 1'b0, 32'h0);
    send(ACT_REMOVE, 8'h21, 32'h0, 16'h0, 1'b0, 32'h0);
    send(ACT_UPDATE, 8'hFF, 32'h1, 16'h0, 1'b0, 32'h0);
    send(3'd5, 8'hA5, 32'h0, 16'h0, 1'b0, 32'h0);
    send(3'd7, 8'h3C, 32'h0, 16'h0, 1'b0, 32'h0);
    send(ACT_TICK, 8'h00, 32'h0, 16'h0, 1'b0, 32'h0);
    send(ACT_TICK, 8'h00, 32'h0, 16'h0, 1'b0, 32'h0);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 9 : (phase == 1 ? 88 : 0);
      recv_idle_pct = phase == 0 ? 88 : (phase == 1 ? 9 : 0);
      for (int k = 0; k < 36; k++) send_random();
    end
    in_tvalid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Sent %0d requests across three pacing phases; %0d timer fire results checked.",
             n_requests, fire_seen);
    if (fail_count == 0) $display("periodic_task_timer_table_core: match");
    else $display("periodic_task_timer_table_core: mismatch");
    $finish;
  end

  initial begin
    #40ms;
    $display("periodic_task_timer_table_core: mismatch");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/ptt_pkg.sv
rtl/ptt_div.sv
rtl/ptt_ctrl.sv
rtl/ptt_dp.sv
rtl/periodic_task_timer_table_core.sv
tb/ptt_checker.sv
tb/testbench.sv
